### hw/rtl/rgbhsv_pkg.sv
// rgbhsv_pkg: shared types and constants for the RGB to HSV pixel converter.
// No dependencies.

package rgbhsv_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned Steps   = 8;
	localparam int unsigned SatNumW = 16;
	localparam int unsigned HueNumW = 14;

	localparam logic [ChanW-1:0] SatScale = 8'd255;
	localparam logic [5:0]       HueScale = 6'd43;
	localparam logic [ChanW-1:0] BaseRed   = 8'd0;
	localparam logic [ChanW-1:0] BaseGreen = 8'd85;
	localparam logic [ChanW-1:0] BaseBlue  = 8'd171;

	// Request state carried through the divider chain
	typedef struct packed {
		logic [SatNumW-1:0] rem_sat;
		logic [HueNumW-1:0] rem_hue;
		logic [ChanW-1:0]   den_sat;
		logic [ChanW-1:0]   den_hue;
		logic [ChanW-1:0]   q_sat;
		logic [ChanW-1:0]   q_hue;
		logic [ChanW-1:0]   base;
		logic               neg;
		logic [ChanW-1:0]   bright;
		logic               last;
	} div_state_t;

endpackage

### hw/rtl/rgbhsv_front.sv
// rgbhsv_front: unpacks the pixel, finds max, min and sector, and forms both
// dividends and divisors. Depends on rgbhsv_pkg.

module rgbhsv_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [23:0]             pixel_rgb,
	input  logic                    last_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output rgbhsv_pkg::div_state_t  out_state
);
	import rgbhsv_pkg::*;

	logic [ChanW-1:0] r, g, b, mx, mn, delta, op_a, op_b, mag, base;
	logic             red_max, green_max;
	logic             valid_s1;
	div_state_t       st_n, st_s1;

	assign r = pixel_rgb[7:0];
	assign g = pixel_rgb[15:8];
	assign b = pixel_rgb[23:16];

	always_comb begin
		red_max   = (r >= g) && (r >= b);
		green_max = !red_max && (g >= b);
		mx = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
		mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
		delta = mx - mn;
		priority if (red_max) begin
			op_a = g;
			op_b = b;
			base = BaseRed;
		end else if (green_max) begin
			op_a = b;
			op_b = r;
			base = BaseGreen;
		end else begin
			op_a = r;
			op_b = g;
			base = BaseBlue;
		end
		mag = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);

		st_n.rem_sat = SatNumW'(delta) * SatNumW'(SatScale);
		st_n.rem_hue = HueNumW'(mag) * HueNumW'(HueScale);
		// zero divisor only ever meets a zero dividend; 1 keeps the quotient 0
		st_n.den_sat = (mx == '0) ? ChanW'(1) : mx;
		st_n.den_hue = (delta == '0) ? ChanW'(1) : delta;
		st_n.q_sat   = '0;
		st_n.q_hue   = '0;
		st_n.base    = base;
		st_n.neg     = op_a < op_b;
		st_n.bright  = mx;
		st_n.last    = last_in;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			st_s1 <= st_n;
		end
	end

	assign out_valid = valid_s1;
	assign out_state = st_s1;

endmodule

### hw/rtl/rgbhsv_div_cell.sv
// rgbhsv_div_cell: one restoring-division step for both quotients, one bit
// per cell, registered. Depends on rgbhsv_pkg.

module rgbhsv_div_cell #(
	parameter int unsigned K = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  rgbhsv_pkg::div_state_t  in_state,
	output logic                    out_valid,
	input  logic                    out_ready,
	output rgbhsv_pkg::div_state_t  out_state
);
	import rgbhsv_pkg::*;

	logic [SatNumW-1:0] dsh_sat, dsh_hue, rem_hue_x;
	logic               valid_q;
	div_state_t         st_n, st_q;

	always_comb begin
		st_n      = in_state;
		dsh_sat   = SatNumW'(in_state.den_sat) << K;
		dsh_hue   = SatNumW'(in_state.den_hue) << K;
		rem_hue_x = SatNumW'(in_state.rem_hue);
		if (in_state.rem_sat >= dsh_sat) begin
			st_n.rem_sat  = in_state.rem_sat - dsh_sat;
			st_n.q_sat[K] = 1'b1;
		end
		if (rem_hue_x >= dsh_hue) begin
			st_n.rem_hue  = HueNumW'(rem_hue_x - dsh_hue);
			st_n.q_hue[K] = 1'b1;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			st_q <= st_n;
		end
	end

	assign out_valid = valid_q;
	assign out_state = st_q;

endmodule

### hw/rtl/rgb_to_hsv_pixel.sv
// rgb_to_hsv_pixel: 8-bit RGB to HSV converter, top level.
// Depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_div_cell.
//
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | pixel_rgb[23:0], last_in
//  output  | out_valid / out_ready| hue, saturation, brightness, last_out
//
// One request per cycle sustained while out_ready is high. Stages: front stage,
// eight quotient-bit cells, output register. The divider chain is one bit per cell.
// Reset clears the valid bit of every stage. A stall at the output backs up
// stage by stage, so empty stages still fill while the output waits.

module rgb_to_hsv_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] pixel_rgb,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  hue,
	output logic [7:0]  saturation,
	output logic [7:0]  brightness,
	output logic        last_out
);
	import rgbhsv_pkg::*;

	logic       chain_valid [Steps+1];
	logic       chain_ready [Steps+1];
	div_state_t chain_state [Steps+1];

	logic [ChanW-1:0] hue_n, hue_s10, sat_s10, bright_s10;
	logic             last_s10, valid_s10, out_stage_ready;

	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_rgb (pixel_rgb),
		.last_in   (last_in),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_state (chain_state[0])
	);

	for (genvar i = 0; i < Steps; i++) begin : g_cell
		rgbhsv_div_cell #(
			.K (Steps - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_state  (chain_state[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_state (chain_state[i+1])
		);
	end

	// truncation toward zero: negate the magnitude quotient
	assign hue_n = chain_state[Steps].neg
		? chain_state[Steps].base - chain_state[Steps].q_hue
		: chain_state[Steps].base + chain_state[Steps].q_hue;

	assign out_stage_ready    = !valid_s10 || out_ready;
	assign chain_ready[Steps] = out_stage_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (out_stage_ready) begin
			valid_s10 <= chain_valid[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (out_stage_ready && chain_valid[Steps]) begin
			hue_s10    <= hue_n;
			sat_s10    <= chain_state[Steps].q_sat;
			bright_s10 <= chain_state[Steps].bright;
			last_s10   <= chain_state[Steps].last;
		end
	end

	assign out_valid  = valid_s10;
	assign hue        = hue_s10;
	assign saturation = sat_s10;
	assign brightness = bright_s10;
	assign last_out   = last_s10;

	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (brightness == 8'd0) |-> (saturation == 8'd0) && (hue == 8'd0))
		else $error("black pixel with nonzero hue or saturation");

	a_grey_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (saturation == 8'd0) |-> (hue == 8'd0))
		else $error("zero saturation with nonzero hue");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output stage is empty");

endmodule
